// ===== rtl/forot_pkg.sv =====
// Shared constants, angle table and item types of the frequency offset rotator.
package forot_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int INDEX_BITS_DEF    = 24;
    localparam int MID_DEPTH_DEF     = 8;

    localparam int SAMPLE_W        = 16;
    localparam int ROT_W           = SAMPLE_W + 1;
    localparam int PHASE_W         = 32;
    localparam int FRAC_BITS       = 12;
    localparam int XY_W            = 32;
    localparam int PROD_W          = 64;
    localparam int ROUND_POS       = FRAC_BITS + 31;
    localparam int MAG_W           = 20;
    localparam int ANGLE_TABLE_LEN = 24;

    localparam logic signed [XY_W-1:0] GAIN_Q31 = 32'sd1304065748;

    // atan(2^-i) in units of 2^-32 turn, truncated
    localparam logic [PHASE_W-1:0] ATAN_TURN [ANGLE_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
        32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // Quadrant codes of the pre-rotation
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    // Pre-rotated sample and residual angle, handed from front to back
    typedef struct packed {
        logic signed [ROT_W-1:0]   x;
        logic signed [ROT_W-1:0]   y;
        logic signed [PHASE_W-1:0] z;
        logic                      last;
    } rot_cmd_t;

    // Finished result item
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic                       sat;
        logic                       last;
    } rot_res_t;

endpackage

// ===== rtl/forot_fifo.sv =====
// Small first-in first-out queue of generic items, read from the head without delay.
module forot_fifo #(
    parameter type ITEM_T = logic,
    parameter int  DEPTH  = 8
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  ITEM_T wr_data,
    input  logic  rd_en,
    output ITEM_T rd_data,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ITEM_T            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assign rd_data = mem[rd_ptr_reg];
    assign empty   = (cnt_reg == '0);

endmodule

// ===== rtl/forot_front.sv =====
// Front end: input transfer, phase register, phase product and quadrant pre-rotation.
module forot_front #(
    parameter int INDEX_BITS = forot_pkg::INDEX_BITS_DEF,
    parameter int MID_DEPTH  = forot_pkg::MID_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [forot_pkg::SAMPLE_W-1:0] sample_re,
    input  logic signed [forot_pkg::SAMPLE_W-1:0] sample_im,
    input  logic [INDEX_BITS-1:0]                 sample_index,
    input  logic                                  last_sample,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [forot_pkg::PHASE_W-1:0]         cfg_data,
    input  logic                                  mid_pop,
    output forot_pkg::rot_cmd_t                   cmd,
    output logic                                  cmd_valid
);

    localparam int CNT_W  = $clog2(MID_DEPTH + 1);
    localparam int PROD_W = INDEX_BITS + forot_pkg::PHASE_W;

    logic [forot_pkg::PHASE_W-1:0] phase_step_reg;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          accept;

    // stage 1: captured input
    logic                                  v1_reg;
    logic signed [forot_pkg::SAMPLE_W-1:0] re1_reg, im1_reg;
    logic [INDEX_BITS-1:0]                 idx1_reg;
    logic                                  last1_reg;

    // stage 2: phase
    logic                                  v2_reg;
    logic signed [forot_pkg::SAMPLE_W-1:0] re2_reg, im2_reg;
    logic [forot_pkg::PHASE_W-1:0]         p2_reg;
    logic                                  last2_reg;
    logic [PROD_W-1:0]                     phase_full;

    // stage 3: pre-rotated command
    logic                                  v3_reg;
    forot_pkg::rot_cmd_t                   cmd_reg, cmd_next;
    logic [forot_pkg::PHASE_W-1:0]         phase_rnd;
    logic [forot_pkg::PHASE_W-1:0]         resid;
    forot_pkg::quad_t                      quad;
    logic signed [forot_pkg::ROT_W-1:0]    re_ext, im_ext;

    assign cfg_ready = 1'b1;
    assign full      = (cnt_reg == CNT_W'(MID_DEPTH));
    assign accept    = push && !full;

    // Count items between the input and the back end's launch
    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept && !mid_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!accept && mid_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            cnt_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                phase_step_reg <= cfg_data;
            end
            cnt_reg <= cnt_next;
            v1_reg  <= accept;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
        end
    end

    assign phase_full = PROD_W'(idx1_reg) * PROD_W'(phase_step_reg);

    always_comb
    begin
        phase_rnd = p2_reg + 32'h2000_0000;
        quad      = forot_pkg::quad_t'(phase_rnd[forot_pkg::PHASE_W-1 -: 2]);
        resid     = p2_reg - {phase_rnd[forot_pkg::PHASE_W-1 -: 2], 30'd0};
        re_ext    = {re2_reg[forot_pkg::SAMPLE_W-1], re2_reg};
        im_ext    = {im2_reg[forot_pkg::SAMPLE_W-1], im2_reg};
        cmd_next.z    = $signed(resid);
        cmd_next.last = last2_reg;
        unique case (quad)
            forot_pkg::QUAD_0:
            begin
                cmd_next.x = re_ext;
                cmd_next.y = im_ext;
            end
            forot_pkg::QUAD_90:
            begin
                cmd_next.x = -im_ext;
                cmd_next.y = re_ext;
            end
            forot_pkg::QUAD_180:
            begin
                cmd_next.x = -re_ext;
                cmd_next.y = -im_ext;
            end
            default:
            begin
                cmd_next.x = im_ext;
                cmd_next.y = -re_ext;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        re1_reg   <= sample_re;
        im1_reg   <= sample_im;
        idx1_reg  <= sample_index;
        last1_reg <= last_sample;
        re2_reg   <= re1_reg;
        im2_reg   <= im1_reg;
        p2_reg    <= phase_full[forot_pkg::PHASE_W-1:0];
        last2_reg <= last1_reg;
        cmd_reg   <= cmd_next;
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = v3_reg;

endmodule

// ===== rtl/forot_back.sv =====
// Back end: CORDIC pipeline, gain multiply, rounding and saturation.
module forot_back #(
    parameter int CORDIC_STAGES = forot_pkg::CORDIC_STAGES_DEF,
    parameter int OUT_DEPTH     = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  forot_pkg::rot_cmd_t cmd,
    input  logic                mid_empty,
    output logic                mid_pop,
    input  logic                out_take,
    output forot_pkg::rot_res_t res,
    output logic                res_valid
);

    localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int XY_W   = forot_pkg::XY_W;
    localparam int EXT_W  = XY_W - forot_pkg::ROT_W - forot_pkg::FRAC_BITS;
    localparam int PROD_W = forot_pkg::PROD_W;
    localparam int MAG_W  = forot_pkg::MAG_W;
    localparam int SW     = forot_pkg::SAMPLE_W;

    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [XY_W-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] z_reg [CORDIC_STAGES+1];
    logic                   last_reg [CORDIC_STAGES+1];
    logic                   v_reg [CORDIC_STAGES+1];

    logic signed [XY_W-1:0] x_next [CORDIC_STAGES];
    logic signed [XY_W-1:0] y_next [CORDIC_STAGES];
    logic signed [XY_W-1:0] z_next [CORDIC_STAGES];

    logic signed [PROD_W-1:0] px_reg, py_reg;
    logic                     pv_reg, plast_reg;

    logic [MAG_W-1:0] rx_mag_reg, ry_mag_reg;
    logic             rx_neg_reg, ry_neg_reg;
    logic             rv_reg, rlast_reg;

    logic [SW:0] sat_x, sat_y;

    // Magnitude rounded half away from zero at the output binary point
    function automatic logic [MAG_W-1:0] round_mag(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] mag;
        logic [PROD_W-1:0] sum;
        mag = p[PROD_W-1] ? (~p + 1'b1) : p;
        sum = mag + (PROD_W'(1) << (forot_pkg::ROUND_POS - 1));
        return sum[forot_pkg::ROUND_POS +: MAG_W];
    endfunction

    // Returns {clipped, value}
    function automatic logic [SW:0] clip16(input logic neg, input logic [MAG_W-1:0] mag);
        logic [SW:0] r;
        if (!neg)
        begin
            if (mag > MAG_W'(32767))
            begin
                r = {1'b1, 16'h7FFF};
            end
            else
            begin
                r = {1'b0, mag[SW-1:0]};
            end
        end
        else
        begin
            if (mag > MAG_W'(32768))
            begin
                r = {1'b1, 16'h8000};
            end
            else
            begin
                r = {1'b0, 16'(~mag[SW-1:0] + 1'b1)};
            end
        end
        return r;
    endfunction

    // Launch from the queue only while the output queue has room for everything in flight
    assign mid_pop = !mid_empty && (cnt_reg < CNT_W'(OUT_DEPTH));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (mid_pop && !out_take)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!mid_pop && out_take)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            if (!z_reg[i][XY_W-1])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - $signed(forot_pkg::ATAN_TURN[i]);
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + $signed(forot_pkg::ATAN_TURN[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            for (int i = 0; i <= CORDIC_STAGES; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            pv_reg <= 1'b0;
            rv_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            v_reg[0] <= mid_pop;
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
            pv_reg <= v_reg[CORDIC_STAGES];
            rv_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= {{EXT_W{cmd.x[forot_pkg::ROT_W-1]}}, cmd.x,
                        {forot_pkg::FRAC_BITS{1'b0}}};
        y_reg[0]    <= {{EXT_W{cmd.y[forot_pkg::ROT_W-1]}}, cmd.y,
                        {forot_pkg::FRAC_BITS{1'b0}}};
        z_reg[0]    <= cmd.z;
        last_reg[0] <= cmd.last;
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            x_reg[i+1]    <= x_next[i];
            y_reg[i+1]    <= y_next[i];
            z_reg[i+1]    <= z_next[i];
            last_reg[i+1] <= last_reg[i];
        end
        px_reg     <= PROD_W'(x_reg[CORDIC_STAGES]) * PROD_W'(forot_pkg::GAIN_Q31);
        py_reg     <= PROD_W'(y_reg[CORDIC_STAGES]) * PROD_W'(forot_pkg::GAIN_Q31);
        plast_reg  <= last_reg[CORDIC_STAGES];
        rx_mag_reg <= round_mag(px_reg);
        ry_mag_reg <= round_mag(py_reg);
        rx_neg_reg <= px_reg[PROD_W-1];
        ry_neg_reg <= py_reg[PROD_W-1];
        rlast_reg  <= plast_reg;
    end

    assign sat_x = clip16(rx_neg_reg, rx_mag_reg);
    assign sat_y = clip16(ry_neg_reg, ry_mag_reg);

    assign res.re    = $signed(sat_x[SW-1:0]);
    assign res.im    = $signed(sat_y[SW-1:0]);
    assign res.sat   = sat_x[SW] | sat_y[SW];
    assign res.last  = rlast_reg;
    assign res_valid = rv_reg;

endmodule

// ===== rtl/frequency_offset_rotator.sv =====
// Path: input, phase and command registers, mid queue, CORDIC stages, gain, round, output queue.
// Throughput: one sample per cycle, sustained while results are popped each cycle.
// The output queue holds a power of two >= CORDIC_STAGES + 5 results; the back end
// launches only with room for every item in flight, so a stalled reader fills it first.
// Reset: asynchronous, active low; clears the queues, pipeline valids and phase_step.
// The NCO phase is sample_index * phase_step modulo one turn, no running accumulator.
module frequency_offset_rotator #(
    parameter int CORDIC_STAGES = forot_pkg::CORDIC_STAGES_DEF,
    parameter int INDEX_BITS    = forot_pkg::INDEX_BITS_DEF,
    parameter int MID_DEPTH     = forot_pkg::MID_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [forot_pkg::SAMPLE_W-1:0] sample_re,
    input  logic signed [forot_pkg::SAMPLE_W-1:0] sample_im,
    input  logic [INDEX_BITS-1:0]                 sample_index,
    input  logic                                  last_sample,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [forot_pkg::PHASE_W-1:0]         cfg_data,
    input  logic                                  pop,
    output logic                                  empty,
    output logic signed [forot_pkg::SAMPLE_W-1:0] out_re,
    output logic signed [forot_pkg::SAMPLE_W-1:0] out_im,
    output logic                                  saturated,
    output logic                                  last_out
);

    localparam int OUT_DEPTH = 1 << $clog2(CORDIC_STAGES + 5);

    forot_pkg::rot_cmd_t cmd, mid_head;
    logic                cmd_valid;
    logic                mid_pop, mid_empty;
    forot_pkg::rot_res_t res, out_head;
    logic                res_valid;
    logic                out_take;

    assign out_take = pop && !empty;

    forot_front #(
        .INDEX_BITS (INDEX_BITS),
        .MID_DEPTH  (MID_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .sample_index (sample_index),
        .last_sample  (last_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .mid_pop      (mid_pop),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid)
    );

    forot_fifo #(
        .ITEM_T (forot_pkg::rot_cmd_t),
        .DEPTH  (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (mid_pop),
        .rd_data (mid_head),
        .empty   (mid_empty)
    );

    forot_back #(
        .CORDIC_STAGES (CORDIC_STAGES),
        .OUT_DEPTH     (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (mid_head),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_take  (out_take),
        .res       (res),
        .res_valid (res_valid)
    );

    forot_fifo #(
        .ITEM_T (forot_pkg::rot_res_t),
        .DEPTH  (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (out_take),
        .rd_data (out_head),
        .empty   (empty)
    );

    assign out_re    = out_head.re;
    assign out_im    = out_head.im;
    assign saturated = out_head.sat;
    assign last_out  = out_head.last;

endmodule

// ===== rtl/forot_checker.sv =====
// Port-level checks of the rotator queue interfaces, bound to the top level.
module forot_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  push,
    input logic                                  full,
    input logic                                  pop,
    input logic                                  empty,
    input logic signed [forot_pkg::SAMPLE_W-1:0] out_re,
    input logic signed [forot_pkg::SAMPLE_W-1:0] out_im,
    input logic                                  saturated,
    input logic                                  last_out
);

    logic [15:0] pending_reg, pending_next;
    logic        in_xfer, out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    // Track samples transferred in whose results are not yet transferred out
    always_comb
    begin
        pending_next = pending_reg;
        if (in_xfer && !out_xfer)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!in_xfer && out_xfer)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pending_reg != 16'd0)
        else $error("result shown with no sample pending");

    a_idle_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 16'd0 |-> !full)
        else $error("full with nothing pending");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_re) && $stable(out_im)
                           && $stable(saturated) && $stable(last_out))
        else $error("waiting result changed or vanished");

endmodule

bind frequency_offset_rotator forot_checker u_forot_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .out_re    (out_re),
    .out_im    (out_im),
    .saturated (saturated),
    .last_out  (last_out)
);

// ===== tb/sv/frequency_offset_rotator_tb.sv =====
// Self-checking testbench of the frequency offset rotator with a scoreboard class.
`timescale 1ns / 100ps

module frequency_offset_rotator_tb;

    localparam int STAGES      = forot_pkg::CORDIC_STAGES_DEF;
    localparam int IDX_W       = forot_pkg::INDEX_BITS_DEF;
    localparam int SW          = forot_pkg::SAMPLE_W;
    localparam int LATENCY     = STAGES + 7;
    localparam int HOLD_CYCLES = 300;

    // Rotation predictor plus the queue of results still owed by the block
    class rotation_scoreboard;
        forot_pkg::rot_res_t expected_rot[$];
        logic [31:0]         step;
        int                  mismatches;

        function new();
            step = '0;
            mismatches = 0;
        endfunction

        function void set_step(logic [31:0] value);
            step = value;
        endfunction

        function int pending();
            return expected_rot.size();
        endfunction

        // Round at the gain binary point, half away from zero, then clip to 16 bits
        function logic signed [SW-1:0] round_saturate(longint v, inout bit sat);
            longint mag;
            longint r;
            bit     neg;
            neg = v < 0;
            mag = neg ? -v : v;
            mag = (mag + (longint'(1) <<< (forot_pkg::ROUND_POS - 1)))
                  >>> forot_pkg::ROUND_POS;
            if (mag > 40000)
                mag = 40000;
            r = neg ? -mag : mag;
            if (r > 32767)
            begin
                r = 32767;
                sat = 1'b1;
            end
            if (r < -32768)
            begin
                r = -32768;
                sat = 1'b1;
            end
            return r[SW-1:0];
        endfunction

        function forot_pkg::rot_res_t rotate_sample(logic signed [SW-1:0] re,
                                                    logic signed [SW-1:0] im,
                                                    logic [IDX_W-1:0] idx, logic lst);
            longint              prod;
            logic [31:0]         phase;
            logic [31:0]         biased;
            logic [31:0]         resid;
            forot_pkg::quad_t    quad;
            longint              x, y, z, dx, dy;
            bit                  sat;
            forot_pkg::rot_res_t r;
            prod   = longint'(idx) * longint'(step);
            phase  = prod[31:0];
            biased = phase + 32'h2000_0000;
            quad   = forot_pkg::quad_t'(biased[31:30]);
            resid  = phase - {quad, 30'b0};
            z      = longint'(signed'(resid));
            case (quad)
                forot_pkg::QUAD_0:
                begin
                    x = re;
                    y = im;
                end
                forot_pkg::QUAD_90:
                begin
                    x = -im;
                    y = re;
                end
                forot_pkg::QUAD_180:
                begin
                    x = -re;
                    y = -im;
                end
                default:
                begin
                    x = im;
                    y = -re;
                end
            endcase
            x = x <<< forot_pkg::FRAC_BITS;
            y = y <<< forot_pkg::FRAC_BITS;
            for (int i = 0; i < STAGES && i < forot_pkg::ANGLE_TABLE_LEN; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= longint'(forot_pkg::ATAN_TURN[i]);
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += longint'(forot_pkg::ATAN_TURN[i]);
                end
            end
            sat    = 1'b0;
            r.re   = round_saturate(x * longint'(forot_pkg::GAIN_Q31), sat);
            r.im   = round_saturate(y * longint'(forot_pkg::GAIN_Q31), sat);
            r.sat  = sat;
            r.last = lst;
            return r;
        endfunction

        function void note_sample(logic signed [SW-1:0] re,
                                  logic signed [SW-1:0] im,
                                  logic [IDX_W-1:0] idx, logic lst);
            expected_rot.push_back(rotate_sample(re, im, idx, lst));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t: %s", $time, msg);
        endtask

        task check_result(forot_pkg::rot_res_t got);
            forot_pkg::rot_res_t want;
            if (expected_rot.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: re %0d im %0d",
                                          got.re, got.im));
                return;
            end
            want = expected_rot.pop_front();
            if (got.re !== want.re)
                report_mismatch($sformatf("out_re got %0d, expected %0d", got.re, want.re));
            if (got.im !== want.im)
                report_mismatch($sformatf("out_im got %0d, expected %0d", got.im, want.im));
            if (got.sat !== want.sat)
                report_mismatch($sformatf("saturated got %0b, expected %0b",
                                          got.sat, want.sat));
            if (got.last !== want.last)
                report_mismatch($sformatf("last_out got %0b, expected %0b",
                                          got.last, want.last));
        endtask
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              push;
    logic                              full;
    logic signed [SW-1:0]              sample_re;
    logic signed [SW-1:0]              sample_im;
    logic [IDX_W-1:0]                  sample_index;
    logic                              last_sample;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [forot_pkg::PHASE_W-1:0]     cfg_data;
    logic                              pop;
    logic                              empty;
    logic signed [SW-1:0]              out_re;
    logic signed [SW-1:0]              out_im;
    logic                              saturated;
    logic                              last_out;

    rotation_scoreboard sb = new();

    bit sender_idles;
    bit reader_idles;
    bit hold_request;
    int hold_left;
    int gap_left;

    frequency_offset_rotator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample_re    (sample_re),
        .sample_im    (sample_im),
        .sample_index (sample_index),
        .last_sample  (last_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .pop          (pop),
        .empty        (empty),
        .out_re       (out_re),
        .out_im       (out_im),
        .saturated    (saturated),
        .last_out     (last_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("frequency_offset_rotator_tb NOT OK");
        $finish;
    end

    // Observe every transfer on the three channels
    always @(posedge clk)
    begin
        forot_pkg::rot_res_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_step(cfg_data);
            if (push && !full)
                sb.note_sample(sample_re, sample_im, sample_index, last_sample);
            if (pop && !empty)
            begin
                got.re   = out_re;
                got.im   = out_im;
                got.sat  = saturated;
                got.last = last_out;
                sb.check_result(got);
            end
        end
    end

    // Reader: long hold-off on request, otherwise random idle bursts while reader_idles is set
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            pop <= 1'b0;
        end
        else if (reader_idles && $urandom_range(0, 7) == 0)
        begin
            gap_left = $urandom_range(0, 9);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(logic signed [SW-1:0] re,
                               logic signed [SW-1:0] im,
                               logic [IDX_W-1:0] idx, logic lst);
        @(negedge clk);
        push         <= 1'b1;
        sample_re    <= re;
        sample_im    <= im;
        sample_index <= idx;
        last_sample  <= lst;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic sender_gap(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    // Stop offering and wait for every owed result
    task automatic drain();
        sender_gap(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_step(logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A span of consecutive indices closed by last, or a broken one with random indices
    task automatic send_span(int len, bit broken);
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] idx;
        logic             lst;
        base = IDX_W'($urandom);
        for (int k = 0; k < len; k++)
        begin
            idx = broken ? IDX_W'($urandom) : IDX_W'(base + k);
            lst = broken ? 1'($urandom) : (k == len - 1);
            send_sample(pick_sample(), pick_sample(), idx, lst);
            if (sender_idles && $urandom_range(0, 7) == 0)
                sender_gap($urandom_range(1, 10));
        end
    endtask

    task automatic run_phase(logic [31:0] step, int count, bit idles);
        int sent;
        int len;
        drain();
        write_step(step);
        sender_idles = idles;
        reader_idles = idles;
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 40);
            send_span(len, $urandom_range(0, 4) == 0);
            sent += len;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        sample_re    = '0;
        sample_im    = '0;
        sample_index = '0;
        last_sample  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        pop          = 1'b0;
        sender_idles = 1'b0;
        reader_idles = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        gap_left     = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // One index step is 1/256 turn: quadrants, the 45 degree quadrant boundaries, extremes
        write_step(32'h0100_0000);
        send_sample(16'sd0, 16'sd0, 24'd0, 1'b0);
        send_sample(16'sh7FFF, 16'sd0, 24'd0, 1'b0);
        send_sample(16'sh8000, 16'sd0, 24'd0, 1'b1);
        send_sample(16'sd0, 16'sh7FFF, 24'd64, 1'b0);
        send_sample(16'sd0, 16'sh8000, 24'd64, 1'b0);
        send_sample(16'sh8000, 16'sd0, 24'd128, 1'b0);
        send_sample(16'sh7FFF, 16'sh8000, 24'd192, 1'b1);
        send_sample(16'sh8000, 16'sh8000, 24'd32, 1'b0);
        send_sample(16'sh7FFF, 16'sh7FFF, 24'd224, 1'b0);
        send_sample(16'sd12345, -16'sd23456, 24'hFF_FFFF, 1'b1);
        send_sample(-16'sd1, 16'sd1, 24'd96, 1'b0);
        send_sample(16'sd1, -16'sd1, 24'd160, 1'b0);
        drain();
        // Tiny negative offset
        write_step(32'hFFFF_FFFF);
        send_sample(16'sd20000, -16'sd20000, 24'd0, 1'b0);
        send_sample(16'sh8000, 16'sh7FFF, 24'd1, 1'b0);
        send_sample(16'sh7FFF, 16'sh8000, 24'hFF_FFFF, 1'b1);
        drain();
        // Half a turn per sample
        write_step(32'h8000_0000);
        send_sample(16'sh8000, 16'sh8000, 24'd1, 1'b0);
        send_sample(16'sd3000, -16'sd7000, 24'd2, 1'b0);
        send_sample(16'sh7FFF, 16'sh7FFF, 24'd3, 1'b1);

        run_phase($urandom, 280, 1'b1);
        run_phase(32'h0000_0001, 250, 1'b1);

        // Stall the reader while the sender keeps going, so the block fills and asserts full
        drain();
        sender_idles = 1'b0;
        hold_request = 1'b1;
        send_span(150, 1'b0);

        run_phase(32'h0004_0000, 250, 1'b1);
        run_phase(32'h0000_0000, 200, 1'b1);
        run_phase($urandom, 250, 1'b1);
        run_phase(32'h8000_0001, 250, 1'b1);
        // Closing stretch runs at full rate on both sides
        run_phase($urandom, 300, 1'b0);

        drain();
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("frequency_offset_rotator_tb OK");
        else
            $display("frequency_offset_rotator_tb NOT OK");
        $finish;
    end

endmodule
